/* hdl/lpfp_pkg.sv */
package lpfp_pkg;

    localparam int CMD_BYTES          = 3;
    localparam int BODY_LENGTH_DIGITS = 10;
    localparam int COUNT_DIGITS       = 6;
    localparam int ITEM_LENGTH_DIGITS = 5;

    localparam int HDR_LEN   = 3 + CMD_BYTES + BODY_LENGTH_DIGITS;
    localparam int DTYPE_POS = 1 + CMD_BYTES;
    localparam int NEXT_POS  = HDR_LEN - 1;

    localparam int FPOS_W = 5;
    localparam int HDR_W  = 48;
    localparam int ACC_W  = 32;
    localparam int LEN_W  = 33;
    localparam int CNT_W  = 20;
    localparam int ILEN_W = 17;
    localparam int CMD_W  = 24;

    localparam logic [ACC_W-1:0] BODY_LEN_CAP = 32'hFFFF_FFFF;
    localparam logic [ACC_W-1:0] COUNT_CAP    = 32'h000F_FFFF;
    localparam logic [ACC_W-1:0] ILEN_CAP     = 32'h0001_FFFF;
    localparam logic [LEN_W-1:0] SEEN_MAX     = 33'h1_FFFF_FFFF;
    localparam logic [LEN_W-1:0] LEN_NEG_MARK = 33'h1_0000_0000;
    localparam logic [HDR_W-1:0] CMD_MASK     = HDR_W'((64'd1 << (8 * CMD_BYTES)) - 64'd1);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 112;
    localparam int M_TUSER_W = 2;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_HEADER,
        PH_COUNT,
        PH_ILEN,
        PH_IDATA,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        DS_BLANK,
        DS_POS,
        DS_NEG,
        DS_DONE_POS,
        DS_DONE_NEG
    } dig_t;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_ITEM_BYTE,
        KIND_EMPTY_ITEM,
        KIND_STATUS
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_START,
        ST_NO_END,
        ST_SHORT,
        ST_MISMATCH
    } status_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic     vld;
        in_item_t item;
    } in_stage_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        system_type;
        logic [CMD_W-1:0]  command_code;
        logic [7:0]        data_type;
        logic [7:0]        next_flag;
        logic [ACC_W-1:0]  body_length;
        logic [CNT_W-1:0]  item_index;
        logic [7:0]        item_data;
        logic              item_final_byte;
        status_t           status_code;
        logic              frame_done;
    } result_t;

    function automatic logic dig_negative(input dig_t ds);
        return (ds == DS_NEG) || (ds == DS_DONE_NEG);
    endfunction

endpackage

/* hdl/lpfp_in_reg.sv */
module lpfp_in_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lpfp_pkg::S_TDATA_W-1:0]  s_tdata,   // frame_byte
    input  logic                            s_tlast,   // frame_end
    input  logic                            take_i,
    output lpfp_pkg::in_stage_t             stage_o
);
    import lpfp_pkg::*;

    logic     vld_reg;
    in_item_t item_reg;

    assign s_tready = !vld_reg || take_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            vld_reg <= 1'b1;
        end else if (take_i) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.frame_byte <= s_tdata[7:0];
            item_reg.frame_end  <= s_tlast;
        end
    end

    assign stage_o.vld  = vld_reg;
    assign stage_o.item = item_reg;

endmodule

/* hdl/lpfp_dec.sv */
module lpfp_dec (
    input  lpfp_pkg::dig_t                  ds_i,
    input  logic [lpfp_pkg::ACC_W-1:0]      acc_i,
    input  logic [lpfp_pkg::ACC_W-1:0]      cap_i,
    input  logic [7:0]                      byte_i,
    output lpfp_pkg::dig_t                  ds_o,
    output logic [lpfp_pkg::ACC_W-1:0]      acc_o
);
    import lpfp_pkg::*;

    logic             is_blank;
    logic             is_digit;
    logic             active;
    logic [ACC_W+3:0] acc_x;
    logic [ACC_W+3:0] prod;

    assign is_blank = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
    assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    assign active   = (ds_i == DS_BLANK) || (ds_i == DS_POS) || (ds_i == DS_NEG);

    // acc * 10 + digit, the low nibble of an ascii digit is its value
    assign acc_x = {4'b0, acc_i};
    assign prod  = (acc_x << 3) + (acc_x << 1) + {{(ACC_W){1'b0}}, byte_i[3:0]};

    always_comb begin
        ds_o  = ds_i;
        acc_o = acc_i;
        if (active) begin
            priority if (is_digit) begin
                if (ds_i == DS_BLANK) begin
                    ds_o = DS_POS;
                end
                acc_o = (prod > {4'b0, cap_i}) ? cap_i : prod[ACC_W-1:0];
            end else if (ds_i == DS_BLANK && is_blank) begin
                ds_o = DS_BLANK;
            end else if (ds_i == DS_BLANK && byte_i == CH_PLUS) begin
                ds_o = DS_POS;
            end else if (ds_i == DS_BLANK && byte_i == CH_MINUS) begin
                ds_o = DS_NEG;
            end else begin
                ds_o = (ds_i == DS_NEG) ? DS_DONE_NEG : DS_DONE_POS;
            end
        end
    end

endmodule

/* hdl/lpfp_core.sv */
module lpfp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           start_marker,
    input  logic [7:0]           end_marker,
    input  lpfp_pkg::in_stage_t  stage_i,
    input  logic                 take_i,
    output logic                 res_vld_o,
    output lpfp_pkg::result_t    res_o
);
    import lpfp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [FPOS_W-1:0] fpos_reg, fpos_next;
    logic              start_ok_reg, start_ok_next;
    logic [HDR_W-1:0]  hdr_reg, hdr_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  seen_reg, seen_next;
    logic [CNT_W-1:0]  items_reg, items_next;
    logic [ILEN_W-1:0] ibl_reg, ibl_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    dig_t              ds_reg, ds_next;

    logic [7:0]        b;
    logic              last;
    logic [ACC_W-1:0]  dec_acc_in;
    logic [ACC_W-1:0]  dec_cap;
    logic [ACC_W-1:0]  dec_acc;
    dig_t              dec_ds;
    logic [FPOS_W-1:0] fpos_inc;
    logic [LEN_W-1:0]  len_fin;
    logic [CNT_W-1:0]  items_fin;
    logic [ILEN_W-1:0] ibl_fin;
    logic [ILEN_W-1:0] ibl_dec;
    logic [CNT_W-1:0]  items_dec;
    logic [CNT_W-1:0]  cur_inc;
    logic              hdr_done;
    logic              count_done;
    logic              ilen_done;
    status_t           status;

    assign b    = stage_i.item.frame_byte;
    assign last = stage_i.item.frame_end;

    always_comb begin
        unique case (phase_reg)
            PH_COUNT: begin
                dec_acc_in = ACC_W'(items_reg);
                dec_cap    = COUNT_CAP;
            end
            PH_ILEN: begin
                dec_acc_in = ACC_W'(ibl_reg);
                dec_cap    = ILEN_CAP;
            end
            default: begin
                dec_acc_in = len_reg[ACC_W-1:0];
                dec_cap    = BODY_LEN_CAP;
            end
        endcase
    end

    lpfp_dec u_dec (
        .ds_i   (ds_reg),
        .acc_i  (dec_acc_in),
        .cap_i  (dec_cap),
        .byte_i (b),
        .ds_o   (dec_ds),
        .acc_o  (dec_acc)
    );

    assign fpos_inc   = fpos_reg + 1'b1;
    assign len_fin    = dig_negative(ds_reg) ? ((len_reg != '0) ? LEN_NEG_MARK : '0) : len_reg;
    assign items_fin  = dig_negative(dec_ds) ? '0 : dec_acc[CNT_W-1:0];
    assign ibl_fin    = dig_negative(dec_ds) ? '0 : dec_acc[ILEN_W-1:0];
    assign ibl_dec    = ibl_reg - 1'b1;
    assign items_dec  = items_reg - 1'b1;
    assign cur_inc    = cur_reg + 1'b1;
    assign hdr_done   = (fpos_reg >= FPOS_W'(NEXT_POS));
    assign count_done = (fpos_inc >= FPOS_W'(COUNT_DIGITS));
    assign ilen_done  = (fpos_inc >= FPOS_W'(ITEM_LENGTH_DIGITS));

    always_comb begin
        priority if (phase_reg == PH_FIRST) begin
            status = (b != start_marker) ? ST_NO_START :
                     (b != end_marker) ? ST_NO_END : ST_SHORT;
        end else if (!start_ok_reg) begin
            status = ST_NO_START;
        end else if (b != end_marker) begin
            status = ST_NO_END;
        end else if (phase_reg == PH_HEADER) begin
            status = ST_SHORT;
        end else if (len_reg[LEN_W-1]) begin
            status = ST_MISMATCH;
        end else if (len_reg != '0 && seen_reg != len_reg) begin
            status = ST_MISMATCH;
        end else begin
            status = ST_OK;
        end
    end

    // next state
    always_comb begin
        phase_next    = phase_reg;
        fpos_next     = fpos_reg;
        start_ok_next = start_ok_reg;
        hdr_next      = hdr_reg;
        len_next      = len_reg;
        seen_next     = seen_reg;
        items_next    = items_reg;
        ibl_next      = ibl_reg;
        cur_next      = cur_reg;
        ds_next       = ds_reg;
        if (last) begin
            phase_next    = PH_FIRST;
            fpos_next     = '0;
            start_ok_next = 1'b0;
            hdr_next      = '0;
            len_next      = '0;
            seen_next     = '0;
            items_next    = '0;
            ibl_next      = '0;
            cur_next      = '0;
            ds_next       = DS_BLANK;
        end else begin
            if (phase_reg != PH_FIRST && phase_reg != PH_HEADER && seen_reg != SEEN_MAX) begin
                seen_next = seen_reg + 1'b1;
            end
            unique case (phase_reg)
                PH_FIRST: begin
                    start_ok_next = (b == start_marker);
                    phase_next    = (b == start_marker) ? PH_HEADER : PH_SKIP;
                end
                PH_HEADER: begin
                    fpos_next = fpos_inc;
                    if (fpos_reg <= FPOS_W'(DTYPE_POS)) begin
                        hdr_next = {hdr_reg[HDR_W-9:0], b};
                    end else if (!hdr_done) begin
                        len_next = {1'b0, dec_acc};
                        ds_next  = dec_ds;
                    end
                    if (hdr_done) begin
                        len_next  = len_fin;
                        seen_next = '0;
                        if (len_fin == '0 || len_fin[LEN_W-1]) begin
                            phase_next = PH_SKIP;
                        end else begin
                            phase_next = PH_COUNT;
                            fpos_next  = '0;
                            ds_next    = DS_BLANK;
                            items_next = '0;
                        end
                    end
                end
                PH_COUNT: begin
                    items_next = dec_acc[CNT_W-1:0];
                    ds_next    = dec_ds;
                    fpos_next  = fpos_inc;
                    if (count_done) begin
                        items_next = items_fin;
                        if (items_fin == '0) begin
                            phase_next = PH_SKIP;
                        end else begin
                            phase_next = PH_ILEN;
                            fpos_next  = '0;
                            ds_next    = DS_BLANK;
                            ibl_next   = '0;
                            cur_next   = '0;
                        end
                    end
                end
                PH_ILEN: begin
                    ibl_next  = dec_acc[ILEN_W-1:0];
                    ds_next   = dec_ds;
                    fpos_next = fpos_inc;
                    if (ilen_done) begin
                        ibl_next = ibl_fin;
                        if (ibl_fin == '0) begin
                            cur_next   = cur_inc;
                            items_next = items_dec;
                            if (items_dec == '0) begin
                                phase_next = PH_SKIP;
                            end else begin
                                phase_next = PH_ILEN;
                                fpos_next  = '0;
                                ds_next    = DS_BLANK;
                            end
                        end else begin
                            phase_next = PH_IDATA;
                        end
                    end
                end
                PH_IDATA: begin
                    ibl_next = ibl_dec;
                    if (ibl_dec == '0) begin
                        cur_next   = cur_inc;
                        items_next = items_dec;
                        if (items_dec == '0) begin
                            phase_next = PH_SKIP;
                        end else begin
                            phase_next = PH_ILEN;
                            fpos_next  = '0;
                            ds_next    = DS_BLANK;
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result
    always_comb begin
        res_vld_o = 1'b0;
        res_o     = '0;
        if (last) begin
            res_vld_o         = 1'b1;
            res_o.kind        = KIND_STATUS;
            res_o.status_code = status;
            res_o.frame_done  = 1'b1;
        end else begin
            unique case (phase_reg)
                PH_HEADER: begin
                    if (hdr_done) begin
                        res_vld_o          = 1'b1;
                        res_o.kind         = KIND_HEADER;
                        res_o.system_type  = hdr_reg[8*(CMD_BYTES+1) +: 8];
                        res_o.command_code = CMD_W'((hdr_reg >> 8) & CMD_MASK);
                        res_o.data_type    = hdr_reg[7:0];
                        res_o.next_flag    = b;
                        res_o.body_length  = len_fin[ACC_W-1:0];
                    end
                end
                PH_ILEN: begin
                    if (ilen_done && ibl_fin == '0) begin
                        res_vld_o        = 1'b1;
                        res_o.kind       = KIND_EMPTY_ITEM;
                        res_o.item_index = cur_reg;
                    end
                end
                PH_IDATA: begin
                    res_vld_o             = 1'b1;
                    res_o.kind            = KIND_ITEM_BYTE;
                    res_o.item_index      = cur_reg;
                    res_o.item_data       = b;
                    res_o.item_final_byte = (ibl_dec == '0);
                end
                default: begin
                    res_vld_o = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_FIRST;
            fpos_reg     <= '0;
            start_ok_reg <= 1'b0;
            hdr_reg      <= '0;
            len_reg      <= '0;
            seen_reg     <= '0;
            items_reg    <= '0;
            ibl_reg      <= '0;
            cur_reg      <= '0;
            ds_reg       <= DS_BLANK;
        end else if (take_i) begin
            phase_reg    <= phase_next;
            fpos_reg     <= fpos_next;
            start_ok_reg <= start_ok_next;
            hdr_reg      <= hdr_next;
            len_reg      <= len_next;
            seen_reg     <= seen_next;
            items_reg    <= items_next;
            ibl_reg      <= ibl_next;
            cur_reg      <= cur_next;
            ds_reg       <= ds_next;
        end
    end

    a_status_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        take_i && last |=> phase_reg == PH_FIRST)
        else $error("parser not back at frame start after status");

    a_idata_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDATA |-> ibl_reg != '0)
        else $error("item data phase with no bytes left");

    a_items_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_ILEN || phase_reg == PH_IDATA) |-> items_reg != '0)
        else $error("item phase with no items left");

    a_bad_start_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        !start_ok_reg && phase_reg != PH_FIRST |-> phase_reg == PH_SKIP)
        else $error("parsing a frame that had a bad start marker");

endmodule

/* hdl/lpfp_out_reg.sv */
module lpfp_out_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            take_i,
    input  logic                            res_vld_i,
    input  lpfp_pkg::result_t               res_i,
    output logic                            ready_o,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lpfp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [lpfp_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import lpfp_pkg::*;

    logic    vld_reg;
    result_t res_reg;

    assign ready_o = !vld_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (take_i) begin
            vld_reg <= res_vld_i;
        end else if (m_tready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_i && res_vld_i) begin
            res_reg <= res_i;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = {res_reg.status_code, res_reg.item_final_byte, res_reg.item_data,
                       res_reg.item_index, res_reg.body_length, res_reg.next_flag,
                       res_reg.data_type, res_reg.command_code, res_reg.system_type};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.frame_done;

endmodule

/* hdl/length_prefixed_frame_parser.sv */
// Parser for marker-delimited frames with a decimal length-prefixed body, fed one byte
// per item with s_tlast on the last byte of a frame. It takes one byte every clock unless
// the output stalls and turns it into at most one result: the header when its last
// character arrives, one result per item byte, a mark for each empty item, and a status
// closing every frame. A byte's result reaches m_tdata through the input register, then
// the result register; the digit accumulate and body length compare in the parser stage
// are combinational. Item bytes come out before the frame's status, so a consumer keeps
// them only when that status is ok. The user must write the start and end markers over
// the cfg port only while no frame is in flight; the block does not enforce this.
module length_prefixed_frame_parser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpfp_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lpfp_pkg::S_TDATA_W-1:0]  s_tdata,   // frame_byte
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // system_type, command_code, data_type, next_flag, body_length, item_index,
    // item_data, item_final_byte, status_code
    output logic [lpfp_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [lpfp_pkg::M_TUSER_W-1:0]  m_tuser,   // kind
    output logic                            m_tlast    // frame_done
);
    import lpfp_pkg::*;

    logic [7:0] start_marker_reg;
    logic [7:0] end_marker_reg;
    in_stage_t  stage;
    logic       out_ready;
    logic       take;
    logic       res_vld;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg <= 8'h02;
            end_marker_reg   <= 8'h03;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_wdata;
                CFG_END_MARKER:   end_marker_reg   <= cfg_wdata;
                default:          start_marker_reg <= start_marker_reg;
            endcase
        end
    end

    assign take = stage.vld && out_ready;

    lpfp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take_i   (take),
        .stage_o  (stage)
    );

    lpfp_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .stage_i      (stage),
        .take_i       (take),
        .res_vld_o    (res_vld),
        .res_o        (res)
    );

    lpfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take_i    (take),
        .res_vld_i (res_vld),
        .res_i     (res),
        .ready_o   (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
